[rtl/dhcp_rop_pkg.sv]
// Shared types and constants for the DHCP request option parser.
package dhcp_rop_pkg;

  localparam int unsigned MAX_BYTES_DEF = 2048;
  localparam int unsigned OFS_W         = 16;
  localparam int unsigned TDATA_W       = 128;

  // Header constants
  localparam logic [7:0]  BOOTP_OP_REQUEST = 8'd1;
  localparam logic [7:0]  ARP_ETHER        = 8'd1;
  localparam logic [7:0]  HW_ADDR_LEN      = 8'd6;
  localparam logic [31:0] BOOTP_MAGIC      = 32'h6382_5363;

  // Option codes
  localparam logic [7:0] OPT_PAD      = 8'd0;
  localparam logic [7:0] OPT_OVERLOAD = 8'd52;
  localparam logic [7:0] OPT_MSG_TYPE = 8'd53;
  localparam logic [7:0] OPT_END      = 8'd255;
  localparam logic [7:0] OVERLOAD_MAX = 8'd3;

  // Verdict status codes
  localparam logic [3:0] ST_OK      = 4'd0;
  localparam logic [3:0] ST_SHORT   = 4'd1;
  localparam logic [3:0] ST_OP      = 4'd2;
  localparam logic [3:0] ST_HTYPE   = 4'd3;
  localparam logic [3:0] ST_HLEN    = 4'd4;
  localparam logic [3:0] ST_GIADDR  = 4'd5;
  localparam logic [3:0] ST_HOPS    = 4'd6;
  localparam logic [3:0] ST_COOKIE  = 4'd7;
  localparam logic [3:0] ST_NOLEN   = 4'd8;
  localparam logic [3:0] ST_TRUNC   = 4'd9;
  localparam logic [3:0] ST_OVLEN   = 4'd10;
  localparam logic [3:0] ST_OVVAL   = 4'd11;
  localparam logic [3:0] ST_NOTYPE  = 4'd12;
  localparam logic [3:0] ST_TOOLONG = 4'd13;

  typedef struct packed {
    logic        kind;
    logic        opt_last;
    logic [7:0]  code;
    logic [7:0]  length;
    logic [7:0]  data;
    logic [7:0]  index;
    logic [3:0]  status;
    logic [1:0]  overload;
    logic [7:0]  msg_type;
    logic [31:0] xid;
    logic [15:0] flags;
    logic [31:0] ciaddr;
  } result_t;

  // Result slots written in one cycle; slot1 only with slot0
  typedef struct packed {
    logic slot0;
    logic slot1;
  } push_t;

endpackage

[rtl/dhcp_rop_fifo.sv]
// Four-entry result queue, up to two writes and one read per cycle.
module dhcp_rop_fifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  dhcp_rop_pkg::push_t   push_i,
  input  dhcp_rop_pkg::result_t item0_i,
  input  dhcp_rop_pkg::result_t item1_i,
  output logic                  room2_o,
  output logic                  valid_o,
  output dhcp_rop_pkg::result_t item_o,
  input  logic                  pop_i
);
  import dhcp_rop_pkg::*;

  localparam int unsigned DEPTH = 4;
  localparam int unsigned PW    = $clog2(DEPTH);
  localparam int unsigned CW    = PW + 1;

  result_t       mem_q [DEPTH];
  logic [PW-1:0] wr_q, rd_q, wr1;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          do_pop;

  assign do_pop  = pop_i && (cnt_q != '0);
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_q];
  assign room2_o = (cnt_q <= CW'(DEPTH - 2));
  assign wr1     = wr_q + PW'(1);

  always_comb begin
    cnt_d = cnt_q + CW'(push_i.slot0) + CW'(push_i.slot1) - CW'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      wr_q  <= wr_q + PW'(push_i.slot0) + PW'(push_i.slot1);
      if (do_pop) rd_q <= rd_q + PW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.slot0) mem_q[wr_q] <= item0_i;
    if (push_i.slot1) mem_q[wr1]  <= item1_i;
  end

  a_slot_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.slot1 |-> push_i.slot0) else $error("second slot pushed alone");
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.slot0 |-> room2_o) else $error("push without room for two");
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(DEPTH)) else $error("queue count out of range");
  a_pop_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_pop && !push_i.slot0) |=> (cnt_q == $past(cnt_q) - CW'(1)))
    else $error("pop did not drop count");

endmodule

[rtl/dhcp_rop_core.sv]
// Parse state and per-byte header check / option walk logic.
module dhcp_rop_core #(
  parameter int unsigned MaxBytes = dhcp_rop_pkg::MAX_BYTES_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  fire_i,
  input  logic [7:0]            byte_i,
  input  logic                  last_i,
  output dhcp_rop_pkg::push_t   push_o,
  output dhcp_rop_pkg::result_t item0_o,
  output dhcp_rop_pkg::result_t item1_o
);
  import dhcp_rop_pkg::*;

  localparam logic [2:0] PH_HEADER = 3'd0;
  localparam logic [2:0] PH_CODE   = 3'd1;
  localparam logic [2:0] PH_LEN    = 3'd2;
  localparam logic [2:0] PH_PAY    = 3'd3;
  localparam logic [2:0] PH_DONE   = 3'd4;
  localparam logic [OFS_W-1:0] MAX_OFS = OFS_W'(MaxBytes);

  logic [OFS_W-1:0] ofs_q, ofs_d;
  logic [2:0]       ph_q, ph_d;
  logic [7:0]       code_q, code_d, len_q, len_d, left_q, left_d;
  logic [3:0]       err_q, err_d, hcode, st;
  logic [1:0]       ov_q, ov_d;
  logic [7:0]       type_q, type_d;
  logic             seen_q, seen_d, long_q, long_d, ovp_q, ovp_d;
  logic             claim_q, claim_d, cap_q, cap_d, pay_v;
  logic [31:0]      xid_q, xid_d, ci_q, ci_d;
  logic [15:0]      flg_q, flg_d;
  result_t          pay, verd;

  always_comb begin
    ofs_d = ofs_q; ph_d = ph_q; code_d = code_q; len_d = len_q; left_d = left_q;
    err_d = err_q; ov_d = ov_q; type_d = type_q; seen_d = seen_q; long_d = long_q;
    ovp_d = ovp_q; claim_d = claim_q; cap_d = cap_q;
    xid_d = xid_q; ci_d = ci_q; flg_d = flg_q;
    hcode = ST_OK;
    pay_v = 1'b0;
    pay   = '0;
    verd  = '0;
    st    = ST_OK;

    if (ofs_q >= MAX_OFS) begin
      long_d = 1'b1;
    end else begin
      case (ph_q)
        PH_HEADER: begin
          if (ofs_q == 16'd0 && byte_i != BOOTP_OP_REQUEST) hcode = ST_OP;
          if (ofs_q == 16'd1 && byte_i != ARP_ETHER)        hcode = ST_HTYPE;
          if (ofs_q == 16'd2 && byte_i != HW_ADDR_LEN)      hcode = ST_HLEN;
          if (ofs_q == 16'd3 && byte_i != 8'd0)             hcode = ST_HOPS;
          if (ofs_q >= 16'd24 && ofs_q <= 16'd27 && byte_i != 8'd0) hcode = ST_GIADDR;
          if (ofs_q == 16'd236 && byte_i != BOOTP_MAGIC[31:24]) hcode = ST_COOKIE;
          if (ofs_q == 16'd237 && byte_i != BOOTP_MAGIC[23:16]) hcode = ST_COOKIE;
          if (ofs_q == 16'd238 && byte_i != BOOTP_MAGIC[15:8])  hcode = ST_COOKIE;
          if (ofs_q == 16'd239 && byte_i != BOOTP_MAGIC[7:0])   hcode = ST_COOKIE;
          // keep the lowest header error code
          if (hcode != ST_OK && (err_q == ST_OK || hcode < err_q)) err_d = hcode;
          if (ofs_q >= 16'd4 && ofs_q <= 16'd7)   xid_d = {xid_q[23:0], byte_i};
          if (ofs_q == 16'd10 || ofs_q == 16'd11) flg_d = {flg_q[7:0], byte_i};
          if (ofs_q >= 16'd12 && ofs_q <= 16'd15) ci_d  = {ci_q[23:0], byte_i};
          if (ofs_q == 16'd239) ph_d = (err_d != ST_OK) ? PH_DONE : PH_CODE;
        end
        PH_CODE: begin
          if (byte_i == OPT_END) begin
            ph_d = PH_DONE;
          end else if (byte_i != OPT_PAD) begin
            code_d = byte_i;
            ph_d   = PH_LEN;
          end
        end
        PH_LEN: begin
          len_d  = byte_i;
          left_d = byte_i;
          ovp_d  = 1'b0;
          ph_d   = (byte_i == 8'd0) ? PH_CODE : PH_PAY;
          if (code_q == OPT_OVERLOAD) begin
            if (byte_i == 8'd0) begin
              err_d = ST_OVLEN;
              ph_d  = PH_DONE;
            end else begin
              ovp_d = (byte_i != 8'd1);
            end
          end else if (code_q == OPT_MSG_TYPE && !claim_q) begin
            claim_d = 1'b1;
            cap_d   = (byte_i == 8'd1);
          end
        end
        PH_PAY: begin
          if (code_q == OPT_OVERLOAD && !ovp_q && byte_i > OVERLOAD_MAX) begin
            err_d = ST_OVVAL;
            ph_d  = PH_DONE;
          end else begin
            if (code_q == OPT_OVERLOAD) begin
              if (!ovp_q) ov_d = byte_i[1:0];
            end else begin
              pay_v        = 1'b1;
              pay.code     = code_q;
              pay.length   = len_q;
              pay.data     = byte_i;
              pay.index    = len_q - left_q;
              pay.opt_last = (left_q == 8'd1);
              if (code_q == OPT_MSG_TYPE && cap_q) begin
                type_d = byte_i;
                seen_d = 1'b1;
                cap_d  = 1'b0;
              end
            end
            left_d = left_q - 8'd1;
            if (left_d == 8'd0) begin
              if (ovp_q) begin
                err_d = ST_OVLEN;
                ph_d  = PH_DONE;
              end else begin
                ph_d = PH_CODE;
              end
            end
          end
        end
        default: ;
      endcase
    end

    if (ofs_q != {OFS_W{1'b1}}) ofs_d = ofs_q + OFS_W'(1);

    if (long_d)                  st = ST_TOOLONG;
    else if (ofs_d < 16'd240)    st = ST_SHORT;
    else if (err_d != ST_OK)     st = err_d;
    else if (ph_d == PH_LEN)     st = ST_NOLEN;
    else if (ph_d == PH_PAY)     st = ST_TRUNC;
    else if (!seen_d)            st = ST_NOTYPE;
    else                         st = ST_OK;

    verd.kind     = 1'b1;
    verd.status   = st;
    verd.overload = ov_d;
    verd.msg_type = type_d;
    verd.xid      = xid_d;
    verd.flags    = flg_d;
    verd.ciaddr   = ci_d;

    // a verdict ends the datagram: back to reset state
    if (last_i) begin
      ofs_d = '0; ph_d = PH_HEADER; code_d = '0; len_d = '0; left_d = '0;
      err_d = ST_OK; ov_d = '0; type_d = '0; seen_d = 1'b0; long_d = 1'b0;
      ovp_d = 1'b0; claim_d = 1'b0; cap_d = 1'b0;
      xid_d = '0; ci_d = '0; flg_d = '0;
    end
  end

  assign push_o.slot0 = fire_i && (pay_v || last_i);
  assign push_o.slot1 = fire_i && pay_v && last_i;
  assign item0_o      = pay_v ? pay : verd;
  assign item1_o      = verd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ofs_q <= '0; ph_q <= PH_HEADER; code_q <= '0; len_q <= '0; left_q <= '0;
      err_q <= ST_OK; ov_q <= '0; type_q <= '0; seen_q <= 1'b0; long_q <= 1'b0;
      ovp_q <= 1'b0; claim_q <= 1'b0; cap_q <= 1'b0;
      xid_q <= '0; ci_q <= '0; flg_q <= '0;
    end else if (fire_i) begin
      ofs_q <= ofs_d; ph_q <= ph_d; code_q <= code_d; len_q <= len_d; left_q <= left_d;
      err_q <= err_d; ov_q <= ov_d; type_q <= type_d; seen_q <= seen_d; long_q <= long_d;
      ovp_q <= ovp_d; claim_q <= claim_d; cap_q <= cap_d;
      xid_q <= xid_d; ci_q <= ci_d; flg_q <= flg_d;
    end
  end

  a_last_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && last_i) |=> (ofs_q == '0 && ph_q == PH_HEADER))
    else $error("state not cleared after verdict");
  a_pay_after_header: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pay_v |-> (ph_q == PH_PAY && ofs_q >= 16'd240))
    else $error("payload emitted outside option walk");
  a_done_has_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ph_q == PH_DONE && err_q == ST_OK) |-> (ofs_q > 16'd240))
    else $error("walk stopped early without error");

endmodule

[rtl/dhcp_rop_unit_dummy_guard.sv]
// Input request register holding one datagram byte ahead of the parser.
module dhcp_rop_unit_dummy_guard (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  output logic       valid_o,
  input  logic       take_i,
  output logic [7:0] byte_o,
  output logic       last_o
);
  logic       valid_q;
  logic [7:0] byte_q;
  logic       last_q;

  assign in_ready_o = !valid_q || take_i;
  assign valid_o    = valid_q;
  assign byte_o     = byte_q;
  assign last_o     = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      byte_q <= in_byte_i;
      last_q <= in_last_i;
    end
  end

endmodule

[rtl/dhcp_request_option_parser_unit.sv]
// DHCP request parser: one datagram byte per request in, option payload bytes
// and one verdict per datagram out. Each byte is registered, then checked against
// the BOOTP header or walked through the option TLVs, and its
// results land in a four-entry result queue. A new byte is taken every cycle
// while the queue has room for two results; a final byte that also carries an
// option payload byte yields two results, which the queue drains one per cycle,
// so the sustained rate is one byte per cycle as long as the output keeps up.
// Status precedence: toolong, short, lowest header error, option error,
// nolen/trunc at end of datagram, notype.
module dhcp_request_option_parser_unit #(
  parameter int unsigned MAX_BYTES = dhcp_rop_pkg::MAX_BYTES_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [7:0]                       s_axis_tdata,  // [7:0] data_byte
  input  logic                             s_axis_tlast,  // last_byte
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [7:0] option_code, [15:8] option_length, [23:16] data_byte_out,
  // [31:24] byte_index, [35:32] status, [37:36] overload,
  // [45:38] message_type, [77:46] transaction_id, [93:78] header_flags,
  // [125:94] client_addr, [127:126] zero
  output logic [dhcp_rop_pkg::TDATA_W-1:0] m_axis_tdata,
  output logic                             m_axis_tuser,  // kind
  output logic                             m_axis_tlast   // option_last
);
  import dhcp_rop_pkg::*;

  logic       in_v, fire, room2, in_last;
  logic [7:0] in_byte;
  push_t      push;
  result_t    item0, item1, head;

  dhcp_rop_unit_dummy_guard u_inreg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_byte_i  (s_axis_tdata),
    .in_last_i  (s_axis_tlast),
    .valid_o    (in_v),
    .take_i     (fire),
    .byte_o     (in_byte),
    .last_o     (in_last)
  );

  assign fire = in_v && room2;

  dhcp_rop_core #(.MaxBytes(MAX_BYTES)) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .fire_i  (fire),
    .byte_i  (in_byte),
    .last_i  (in_last),
    .push_o  (push),
    .item0_o (item0),
    .item1_o (item1)
  );

  dhcp_rop_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item0_i (item0),
    .item1_i (item1),
    .room2_o (room2),
    .valid_o (m_axis_tvalid),
    .item_o  (head),
    .pop_i   (m_axis_tready)
  );

  assign m_axis_tuser = head.kind;
  assign m_axis_tlast = head.opt_last;
  assign m_axis_tdata = {2'b00, head.ciaddr, head.flags, head.xid, head.msg_type,
                         head.overload, head.status, head.index, head.data,
                         head.length, head.code};

endmodule
